// ===== sv/cst_pkg.sv =====
// Package: token codes, scan states, keyword tables and queue types for the tokenizer.
`timescale 1ns / 1ps
package cst_pkg;

  localparam int MaxTokenLength = 255;

  localparam logic [5:0] K_PLUS    = 6'd9;
  localparam logic [5:0] K_INC     = 6'd10;
  localparam logic [5:0] K_MINUS   = 6'd11;
  localparam logic [5:0] K_DEC     = 6'd12;
  localparam logic [5:0] K_ARROW   = 6'd13;
  localparam logic [5:0] K_STAR    = 6'd14;
  localparam logic [5:0] K_DIV     = 6'd15;
  localparam logic [5:0] K_DIVEQ   = 6'd16;
  localparam logic [5:0] K_ASSIGN  = 6'd17;
  localparam logic [5:0] K_EQ      = 6'd18;
  localparam logic [5:0] K_LT      = 6'd19;
  localparam logic [5:0] K_LE      = 6'd20;
  localparam logic [5:0] K_GT      = 6'd21;
  localparam logic [5:0] K_GE      = 6'd22;
  localparam logic [5:0] K_NOT     = 6'd23;
  localparam logic [5:0] K_NE      = 6'd24;
  localparam logic [5:0] K_AMP     = 6'd25;
  localparam logic [5:0] K_LAND    = 6'd26;
  localparam logic [5:0] K_OR      = 6'd27;
  localparam logic [5:0] K_LOR     = 6'd28;
  localparam logic [5:0] K_OREQ    = 6'd29;
  localparam logic [5:0] K_KEYWORD = 6'd30;
  localparam logic [5:0] K_IDENT   = 6'd31;
  localparam logic [5:0] K_NUMBER  = 6'd32;
  localparam logic [5:0] K_STRING  = 6'd33;
  localparam logic [5:0] K_CHAR    = 6'd34;
  localparam logic [5:0] K_PREPROC = 6'd35;
  localparam logic [5:0] K_END     = 6'd36;
  localparam logic [5:0] K_ERROR   = 6'd37;

  localparam int NumKw  = 23;
  localparam int NumDir = 9;
  localparam int DirIf  = 3;

  typedef enum logic [21:0] {
    S_START        = 22'h000001,
    S_IDENT        = 22'h000002,
    S_NUMBER       = 22'h000004,
    S_PLUS         = 22'h000008,
    S_MINUS        = 22'h000010,
    S_EQ           = 22'h000020,
    S_LT           = 22'h000040,
    S_GT           = 22'h000080,
    S_NOT          = 22'h000100,
    S_AMP          = 22'h000200,
    S_OR           = 22'h000400,
    S_SLASH        = 22'h000800,
    S_COMMENT      = 22'h001000,
    S_COMMENT_STAR = 22'h002000,
    S_STR          = 22'h004000,
    S_STR_ESC      = 22'h008000,
    S_CHR_OPEN     = 22'h010000,
    S_CHR_ESC      = 22'h020000,
    S_CHR_CLOSE    = 22'h040000,
    S_PP_NAME      = 22'h080000,
    S_PP_BODY      = 22'h100000,
    S_PP_ESC       = 22'h200000
  } scan_state_t;

  // One result slot from the scanner.
  typedef struct packed {
    logic       vld;
    logic [5:0] kind;
    logic [7:0] len;
  } tok_t;

  // Queue entry: results caused by one byte (up to two).
  typedef struct packed {
    tok_t a;
    tok_t b;
  } tok_pair_t;

  // Character of keyword k at position p, 0 past its end.
  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] p);
    logic [8*8-1:0] s;
    logic [3:0]     n;
    begin
      s = '0;
      n = 4'd0;
      case (k)
        5'd0:  begin s = "char";     n = 4'd4; end
        5'd1:  begin s = "short";    n = 4'd5; end
        5'd2:  begin s = "int";      n = 4'd3; end
        5'd3:  begin s = "long";     n = 4'd4; end
        5'd4:  begin s = "unsigned"; n = 4'd8; end
        5'd5:  begin s = "float";    n = 4'd5; end
        5'd6:  begin s = "double";   n = 4'd6; end
        5'd7:  begin s = "typedef";  n = 4'd7; end
        5'd8:  begin s = "struct";   n = 4'd6; end
        5'd9:  begin s = "union";    n = 4'd5; end
        5'd10: begin s = "auto";     n = 4'd4; end
        5'd11: begin s = "static";   n = 4'd6; end
        5'd12: begin s = "extern";   n = 4'd6; end
        5'd13: begin s = "register"; n = 4'd8; end
        5'd14: begin s = "if";       n = 4'd2; end
        5'd15: begin s = "else";     n = 4'd4; end
        5'd16: begin s = "while";    n = 4'd5; end
        5'd17: begin s = "do";       n = 4'd2; end
        5'd18: begin s = "for";      n = 4'd3; end
        5'd19: begin s = "switch";   n = 4'd6; end
        5'd20: begin s = "case";     n = 4'd4; end
        5'd21: begin s = "default";  n = 4'd7; end
        5'd22: begin s = "return";   n = 4'd6; end
        default: begin s = '0; n = 4'd0; end
      endcase
      if (p < n) kw_char = s[8*(n-p)-1 -: 8];
      else kw_char = 8'd0;
    end
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    case (k)
      5'd0, 5'd3, 5'd10, 5'd15, 5'd20: kw_len = 4'd4;
      5'd1, 5'd5, 5'd9, 5'd16:         kw_len = 4'd5;
      5'd2, 5'd18:                     kw_len = 4'd3;
      5'd4, 5'd13:                     kw_len = 4'd8;
      5'd6, 5'd8, 5'd11, 5'd12, 5'd19, 5'd22: kw_len = 4'd6;
      5'd7, 5'd21:                     kw_len = 4'd7;
      5'd14, 5'd17:                    kw_len = 4'd2;
      default:                         kw_len = 4'd0;
    endcase
  endfunction

  function automatic logic [7:0] dir_char(input logic [3:0] k, input logic [3:0] p);
    logic [8*8-1:0] s;
    logic [3:0]     n;
    begin
      s = '0;
      n = 4'd0;
      case (k)
        4'd0: begin s = "define";  n = 4'd6; end
        4'd1: begin s = "else";    n = 4'd4; end
        4'd2: begin s = "endif";   n = 4'd5; end
        4'd3: begin s = "if";      n = 4'd2; end
        4'd4: begin s = "ifdef";   n = 4'd5; end
        4'd5: begin s = "ifndef";  n = 4'd6; end
        4'd6: begin s = "include"; n = 4'd7; end
        4'd7: begin s = "line";    n = 4'd4; end
        4'd8: begin s = "undef";   n = 4'd5; end
        default: begin s = '0; n = 4'd0; end
      endcase
      if (p < n) dir_char = s[8*(n-p)-1 -: 8];
      else dir_char = 8'd0;
    end
  endfunction

  function automatic logic [3:0] dir_len(input logic [3:0] k);
    case (k)
      4'd0, 4'd5: dir_len = 4'd6;
      4'd1, 4'd7: dir_len = 4'd4;
      4'd2, 4'd4, 4'd8: dir_len = 4'd5;
      4'd3: dir_len = 4'd2;
      4'd6: dir_len = 4'd7;
      default: dir_len = 4'd0;
    endcase
  endfunction

endpackage

// ===== sv/cst_scan.sv =====
// Front end: byte classification and the scanner state machine.
`timescale 1ns / 1ps
module cst_scan
  import cst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  output tok_pair_t  res
);

  scan_state_t state_r, state_nxt;
  logic [22:0] cand_r, cand_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        hold_r, hold_nxt;

  tok_t  r0, r1;
  logic  n_res;
  logic  is_al, is_dg;
  logic [7:0] len_inc;
  logic [22:0] kw_filt;
  logic [22:0] kw_first;
  logic [8:0]  dir_filt;
  logic        kw_hit;
  logic        dir_done;
  logic        rescan;

  assign is_al = (byte_in >= "a" && byte_in <= "z") || (byte_in >= "A" && byte_in <= "Z") ||
                 byte_in == "_";
  assign is_dg = byte_in >= "0" && byte_in <= "9";
  assign len_inc = (len_r < 8'(MaxTokenLength)) ? len_r + 8'd1 : len_r;

  // Keyword and directive candidate filters, one lane per entry.
  always_comb begin
    kw_hit = 1'b0;
    for (int k = 0; k < NumKw; k++) begin
      kw_first[k] = kw_char(5'(k), 4'd0) == byte_in;
      kw_filt[k]  = cand_r[k] && len_r < 8'(kw_len(5'(k))) &&
                    kw_char(5'(k), len_r[3:0]) == byte_in;
      if (cand_r[k] && 8'(kw_len(5'(k))) == len_r) kw_hit = 1'b1;
    end
    dir_done = 1'b0;
    for (int k = 0; k < NumDir; k++) begin
      dir_filt[k] = cand_r[k] && (len_r - 8'd1) < 8'(dir_len(4'(k))) &&
                    dir_char(4'(k), 4'(len_r - 8'd1)) == byte_in;
      if (dir_filt[k] && 8'(dir_len(4'(k))) == len_r && k != DirIf) dir_done = 1'b1;
    end
  end

  // Push one result into the first free slot.
  function automatic void put(inout tok_t a, inout tok_t b, input logic [5:0] k,
                              input logic [7:0] l);
    if (!a.vld) begin
      a.vld = 1'b1; a.kind = k; a.len = l;
    end else if (!b.vld) begin
      b.vld = 1'b1; b.kind = k; b.len = l;
    end
  endfunction

  always_comb begin
    state_nxt = state_r;
    cand_nxt  = cand_r;
    len_nxt   = len_r;
    hold_nxt  = hold_r;
    r0 = '0;
    r1 = '0;
    rescan = 1'b0;
    n_res = 1'b0;
    if (hold_r) begin
      if (byte_in == 8'd0) begin
        hold_nxt = 1'b0;
        state_nxt = S_START;
        put(r0, r1, K_END, 8'd0);
      end
    end else begin
      case (state_r)
        S_START: rescan = 1'b1;
        S_IDENT:
          if (is_al || is_dg) begin
            cand_nxt = kw_filt; len_nxt = len_inc;
          end else begin
            put(r0, r1, kw_hit ? K_KEYWORD : K_IDENT, len_r);
            rescan = 1'b1;
          end
        S_NUMBER:
          if (is_dg) len_nxt = len_inc;
          else begin
            put(r0, r1, K_NUMBER, len_r); rescan = 1'b1;
          end
        S_PLUS:
          if (byte_in == "+") begin put(r0, r1, K_INC, 8'd2); state_nxt = S_START; end
          else begin put(r0, r1, K_PLUS, 8'd1); rescan = 1'b1; end
        S_MINUS:
          if (byte_in == "-") begin put(r0, r1, K_DEC, 8'd2); state_nxt = S_START; end
          else if (byte_in == ">") begin put(r0, r1, K_ARROW, 8'd2); state_nxt = S_START; end
          else begin put(r0, r1, K_MINUS, 8'd1); rescan = 1'b1; end
        S_EQ:
          if (byte_in == "=") begin put(r0, r1, K_EQ, 8'd2); state_nxt = S_START; end
          else begin put(r0, r1, K_ASSIGN, 8'd1); rescan = 1'b1; end
        S_LT:
          if (byte_in == "=") begin put(r0, r1, K_LE, 8'd2); state_nxt = S_START; end
          else begin put(r0, r1, K_LT, 8'd1); rescan = 1'b1; end
        S_GT:
          if (byte_in == "=") begin put(r0, r1, K_GE, 8'd2); state_nxt = S_START; end
          else begin put(r0, r1, K_GT, 8'd1); rescan = 1'b1; end
        S_NOT:
          if (byte_in == "=") begin put(r0, r1, K_NE, 8'd2); state_nxt = S_START; end
          else begin put(r0, r1, K_NOT, 8'd1); rescan = 1'b1; end
        S_AMP:
          if (byte_in == "&") begin put(r0, r1, K_LAND, 8'd2); state_nxt = S_START; end
          else begin put(r0, r1, K_AMP, 8'd1); rescan = 1'b1; end
        S_OR:
          if (byte_in == "|") begin put(r0, r1, K_LOR, 8'd2); state_nxt = S_START; end
          else if (byte_in == "=") begin put(r0, r1, K_OREQ, 8'd2); state_nxt = S_START; end
          else begin put(r0, r1, K_OR, 8'd1); rescan = 1'b1; end
        S_SLASH:
          if (byte_in == "*") state_nxt = S_COMMENT;
          else if (byte_in == "=") begin put(r0, r1, K_DIVEQ, 8'd2); state_nxt = S_START; end
          else begin put(r0, r1, K_DIV, 8'd1); rescan = 1'b1; end
        S_COMMENT:
          if (byte_in == 8'd0) n_res = 1'b1;
          else if (byte_in == "*") state_nxt = S_COMMENT_STAR;
        S_COMMENT_STAR:
          if (byte_in == 8'd0) n_res = 1'b1;
          else if (byte_in == "/") state_nxt = S_START;
          else if (byte_in != "*") state_nxt = S_COMMENT;
        S_STR:
          if (byte_in == 8'd0) n_res = 1'b1;
          else begin
            len_nxt = len_inc;
            if (byte_in == "\"") begin put(r0, r1, K_STRING, len_inc); state_nxt = S_START; end
            else if (byte_in == "\\") state_nxt = S_STR_ESC;
          end
        S_STR_ESC:
          if (byte_in == 8'd0) n_res = 1'b1;
          else begin len_nxt = len_inc; state_nxt = S_STR; end
        S_CHR_OPEN:
          if (byte_in == 8'd0 || byte_in == "'") n_res = 1'b1;
          else begin
            len_nxt = len_inc;
            state_nxt = (byte_in == "\\") ? S_CHR_ESC : S_CHR_CLOSE;
          end
        S_CHR_ESC:
          if (byte_in == 8'd0) n_res = 1'b1;
          else begin len_nxt = len_inc; state_nxt = S_CHR_CLOSE; end
        S_CHR_CLOSE:
          if (byte_in == "'") begin
            len_nxt = len_inc; put(r0, r1, K_CHAR, len_inc); state_nxt = S_START;
          end else n_res = 1'b1;
        S_PP_NAME:
          if (len_r == 8'd3 && cand_r[DirIf] && byte_in != "d" && byte_in != "n") begin
            // "#if" done: this byte already belongs to the line
            if (byte_in == 8'd0 || byte_in == 8'h0a) begin
              put(r0, r1, K_PREPROC, len_r); rescan = 1'b1;
            end else begin
              len_nxt = len_inc;
              state_nxt = (byte_in == "\\") ? S_PP_ESC : S_PP_BODY;
            end
          end else if (dir_filt == '0) n_res = 1'b1;
          else begin
            cand_nxt = {14'd0, dir_filt};
            len_nxt = len_inc;
            if (dir_done) state_nxt = S_PP_BODY;
          end
        S_PP_BODY:
          if (byte_in == 8'd0 || byte_in == 8'h0a) begin
            put(r0, r1, K_PREPROC, len_r); rescan = 1'b1;
          end else begin
            len_nxt = len_inc;
            if (byte_in == "\\") state_nxt = S_PP_ESC;
          end
        S_PP_ESC:
          if (byte_in == 8'd0) begin put(r0, r1, K_PREPROC, len_r); rescan = 1'b1; end
          else begin len_nxt = len_inc; state_nxt = S_PP_BODY; end
        default: rescan = 1'b1;
      endcase

      if (rescan) begin
        state_nxt = S_START;
        case (byte_in)
          8'd0: put(r0, r1, K_END, 8'd0);
          " ", 8'h09, 8'h0d, 8'h0a: ;
          "(": put(r0, r1, 6'd0, 8'd1);
          ")": put(r0, r1, 6'd1, 8'd1);
          "{": put(r0, r1, 6'd2, 8'd1);
          "}": put(r0, r1, 6'd3, 8'd1);
          "[": put(r0, r1, 6'd4, 8'd1);
          "]": put(r0, r1, 6'd5, 8'd1);
          ";": put(r0, r1, 6'd6, 8'd1);
          ",": put(r0, r1, 6'd7, 8'd1);
          ":": put(r0, r1, 6'd8, 8'd1);
          "*": put(r0, r1, K_STAR, 8'd1);
          "+": begin state_nxt = S_PLUS;  len_nxt = 8'd1; end
          "-": begin state_nxt = S_MINUS; len_nxt = 8'd1; end
          "=": begin state_nxt = S_EQ;    len_nxt = 8'd1; end
          "<": begin state_nxt = S_LT;    len_nxt = 8'd1; end
          ">": begin state_nxt = S_GT;    len_nxt = 8'd1; end
          "!": begin state_nxt = S_NOT;   len_nxt = 8'd1; end
          "&": begin state_nxt = S_AMP;   len_nxt = 8'd1; end
          "|": begin state_nxt = S_OR;    len_nxt = 8'd1; end
          "/": begin state_nxt = S_SLASH; len_nxt = 8'd1; end
          "\"": begin state_nxt = S_STR;  len_nxt = 8'd1; end
          "'": begin state_nxt = S_CHR_OPEN; len_nxt = 8'd1; end
          "#": begin
            state_nxt = S_PP_NAME; len_nxt = 8'd1; cand_nxt = 23'h0001FF;
          end
          default:
            if (is_al) begin
              state_nxt = S_IDENT; len_nxt = 8'd1; cand_nxt = kw_first;
            end else if (is_dg) begin
              state_nxt = S_NUMBER; len_nxt = 8'd1;
            end else n_res = 1'b1;
        endcase
      end

      if (n_res) begin
        // lexical error; a 0 byte ends text at once
        put(r0, r1, K_ERROR, 8'd0);
        state_nxt = S_START;
        hold_nxt = 1'b1;
        if (byte_in == 8'd0) begin
          hold_nxt = 1'b0;
          put(r0, r1, K_END, 8'd0);
        end
      end
    end
    res.a = r0;
    res.b = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_START;
      cand_r  <= '1;
      len_r   <= '0;
      hold_r  <= 1'b0;
    end else if (step) begin
      state_r <= state_nxt;
      cand_r  <= cand_nxt;
      len_r   <= len_nxt;
      hold_r  <= hold_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_hold_start: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r |-> state_r == S_START) else $error("hold outside start state");
  a_b_needs_a: assert property (@(posedge clk) disable iff (!rst_n)
    res.b.vld |-> res.a.vld) else $error("second slot without first");
  a_hold_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_r && byte_in != 8'd0) |-> !res.a.vld) else $error("result during hold");
`endif

endmodule

// ===== sv/cst_queue.sv =====
// Short queue of per-byte result pairs between scanner and output side.
`timescale 1ns / 1ps
module cst_queue
  import cst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tok_pair_t push_data,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output tok_pair_t head
);

  tok_pair_t mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue underflow");
  a_cnt_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count corrupt");
`endif

endmodule

// ===== sv/cst_emit.sv =====
// Back end: splits each result pair into single transfers on the output port.
`timescale 1ns / 1ps
module cst_emit
  import cst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  tok_pair_t  q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_token_kind,
  output logic [7:0] out_token_length,
  output logic       out_last_of_run
);

  logic sel_r;   // 1: first slot already sent
  logic take;

  assign out_valid        = !q_empty && (sel_r ? q_head.b.vld : q_head.a.vld);
  assign out_token_kind   = sel_r ? q_head.b.kind : q_head.a.kind;
  assign out_token_length = sel_r ? q_head.b.len : q_head.a.len;
  assign out_last_of_run  = sel_r || !q_head.b.vld;
  assign take             = out_valid && !out_stall;
  // byte pairs without results are dropped at once
  assign q_pop = !q_empty && (!q_head.a.vld || (take && out_last_of_run));

  always_ff @(posedge clk) begin
    if (!rst_n) sel_r <= 1'b0;
    else if (q_pop) sel_r <= 1'b0;
    else if (take) sel_r <= 1'b1;
  end

`ifndef ASSERT_OFF
  a_sel_b: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> (!q_empty && q_head.b.vld)) else $error("second slot missing");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_stall) |-> out_valid) else $error("valid dropped");
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.a.vld) |-> out_last_of_run) else $error("pop mid pair");
`endif

endmodule

// ===== sv/c_source_tokenizer.sv =====
// Top level: C source tokenizer, scanner front end, result queue and output back end.
`timescale 1ns / 1ps
//
//  channel  | direction | ports                                       | transfer when
//  ---------+-----------+---------------------------------------------+-----------------
//  input    | in        | in_valid, in_stall, in_text_byte            | valid & !stall
//  result   | out       | out_valid, out_stall, out_token_kind,       | valid & !stall
//           |           | out_token_length, out_last_of_run           |
//
//  One byte is scanned per cycle; its results (zero, one or two) enter a
//  two-entry queue in the same cycle, so a new byte is taken every cycle unless
//  the queue is full. A byte giving two results makes two output transfers.
//  in_stall rises only when the queue is full; out_stall backs up the queue.
//  Synchronous active-low reset returns the scanner to its start state.
module c_source_tokenizer
  import cst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_token_kind,
  output logic [7:0] out_token_length,
  output logic       out_last_of_run
);

  tok_pair_t scan_res, q_head;
  logic      q_full, q_empty, q_pop, step;

  assign in_stall = q_full;
  assign step     = in_valid && !q_full;

  cst_scan u_scan (
    .clk(clk), .rst_n(rst_n), .step(step), .byte_in(in_text_byte), .res(scan_res)
  );

  cst_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(step), .push_data(scan_res), .full(q_full),
    .pop(q_pop), .empty(q_empty), .head(q_head)
  );

  cst_emit u_emit (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_token_kind(out_token_kind),
    .out_token_length(out_token_length), .out_last_of_run(out_last_of_run)
  );

`ifndef ASSERT_OFF
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_token_kind <= K_ERROR) else $error("kind out of range");
  a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_token_kind == K_END || out_token_kind == K_ERROR))
      |-> out_token_length == 8'd0) else $error("end/error length");
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_kind == K_END) |-> out_last_of_run) else $error("end not last");
`endif

endmodule

// ===== bench/tok_scoreboard.sv =====
// Checker: watches both channels of the tokenizer, predicts token results and compares.
`timescale 1ns / 1ps
module tok_scoreboard
  import cst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  out_token_kind,
  input  logic [7:0]  out_token_length,
  input  logic        out_last_of_run,
  output int          fail_count,
  output int          pending_count,
  output int          token_count
);

  typedef struct packed {
    logic [5:0] kind;
    logic [7:0] len;
    logic       last;
  } token_t;

  typedef enum int {
    LX_START, LX_IDENT, LX_NUMBER, LX_PLUS, LX_MINUS, LX_EQ, LX_LT, LX_GT, LX_NOT,
    LX_AMP, LX_OR, LX_SLASH, LX_COMMENT, LX_COMMENT_STAR, LX_STR, LX_STR_ESC,
    LX_CHR_OPEN, LX_CHR_ESC, LX_CHR_CLOSE, LX_PP_NAME, LX_PP_BODY, LX_PP_ESC
  } lex_state_t;

  localparam logic [7:0] ChNul = 8'd0;

  token_t     expected_tokens[$];
  token_t     step_tokens[$];
  lex_state_t lx;
  logic [22:0] cand;
  int unsigned tok_len;
  bit          in_error;

  string kw_names[NumKw] = '{"char", "short", "int", "long", "unsigned", "float",
    "double", "typedef", "struct", "union", "auto", "static", "extern", "register",
    "if", "else", "while", "do", "for", "switch", "case", "default", "return"};
  string dir_names[NumDir] = '{"define", "else", "endif", "if", "ifdef", "ifndef",
    "include", "line", "undef"};

  function automatic bit is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic [22:0] narrow(logic [22:0] m, bit dirs, int pos, logic [7:0] b);
    logic [22:0] r;
    string s;
    r = '0;
    for (int k = 0; k < (dirs ? NumDir : NumKw); k++) begin
      s = dirs ? dir_names[k] : kw_names[k];
      if (m[k] && pos < s.len() && s[pos] == b) r[k] = 1'b1;
    end
    return r;
  endfunction

  function automatic void push_tok(logic [5:0] kind, int unsigned len);
    token_t t;
    if (step_tokens.size() >= 2) return;
    t.kind = kind;
    t.len  = (len > 255) ? 8'd255 : len[7:0];
    t.last = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void grow();
    if (tok_len < MaxTokenLength) tok_len++;
  endfunction

  function automatic void lex_error(logic [7:0] b);
    push_tok(K_ERROR, 0);
    lx = LX_START;
    in_error = (b != ChNul);
    if (b == ChNul) push_tok(K_END, 0);
  endfunction

  function automatic void open_tok(lex_state_t s);
    lx = s;
    tok_len = 1;
  endfunction

  function automatic void lex_first(logic [7:0] b);
    lx = LX_START;
    case (b)
      ChNul: push_tok(K_END, 0);
      " ", "\t", 8'd13, "\n": ;
      "(": push_tok(6'd0, 1);
      ")": push_tok(6'd1, 1);
      "{": push_tok(6'd2, 1);
      "}": push_tok(6'd3, 1);
      "[": push_tok(6'd4, 1);
      "]": push_tok(6'd5, 1);
      ";": push_tok(6'd6, 1);
      ",": push_tok(6'd7, 1);
      ":": push_tok(6'd8, 1);
      "*": push_tok(K_STAR, 1);
      "+": open_tok(LX_PLUS);
      "-": open_tok(LX_MINUS);
      "=": open_tok(LX_EQ);
      "<": open_tok(LX_LT);
      ">": open_tok(LX_GT);
      "!": open_tok(LX_NOT);
      "&": open_tok(LX_AMP);
      "|": open_tok(LX_OR);
      "/": open_tok(LX_SLASH);
      8'h22: open_tok(LX_STR);
      8'h27: open_tok(LX_CHR_OPEN);
      "#": begin
        open_tok(LX_PP_NAME);
        cand = 23'h1FF;
      end
      default: begin
        if (is_letter(b)) begin
          open_tok(LX_IDENT);
          cand = narrow('1, 0, 0, b);
        end else if (is_num(b)) begin
          open_tok(LX_NUMBER);
        end else begin
          lex_error(b);
        end
      end
    endcase
  endfunction

  function automatic void lex_op(logic [7:0] b, logic [5:0] one, logic [7:0] c1,
                                 logic [5:0] k1, logic [7:0] c2, logic [5:0] k2);
    if (b == c1) begin
      push_tok(k1, 2);
      lx = LX_START;
    end else if (c2 != ChNul && b == c2) begin
      push_tok(k2, 2);
      lx = LX_START;
    end else begin
      push_tok(one, 1);
      lex_first(b);
    end
  endfunction

  function automatic void lex_pp_body(logic [7:0] b);
    if (b == ChNul || b == "\n") begin
      push_tok(K_PREPROC, tok_len);
      lex_first(b);
    end else begin
      grow();
      if (b == "\\") lx = LX_PP_ESC;
    end
  endfunction

  function automatic void lex_pp_name(logic [7:0] b);
    int pos;
    logic [22:0] nx;
    pos = tok_len - 1;
    if (pos == 2 && cand[DirIf] && b != "d" && b != "n") begin
      lx = LX_PP_BODY;
      lex_pp_body(b);
      return;
    end
    nx = narrow(cand, 1, pos, b);
    if (nx == '0) begin
      lex_error(b);
      return;
    end
    cand = nx;
    grow();
    for (int k = 0; k < NumDir; k++)
      if (nx[k] && dir_names[k].len() == pos + 1 && k != DirIf) lx = LX_PP_BODY;
  endfunction

  // Advance the predicted scanner by one byte; results land in step_tokens.
  function automatic void lex_byte(logic [7:0] b);
    bit kw;
    step_tokens.delete();
    if (in_error) begin
      if (b == ChNul) begin
        in_error = 0;
        lx = LX_START;
        push_tok(K_END, 0);
      end
    end else begin
      case (lx)
        LX_IDENT:
          if (is_letter(b) || is_num(b)) begin
            cand = narrow(cand, 0, tok_len, b);
            grow();
          end else begin
            kw = 0;
            for (int k = 0; k < NumKw; k++)
              if (cand[k] && kw_names[k].len() == tok_len) kw = 1;
            push_tok(kw ? K_KEYWORD : K_IDENT, tok_len);
            lex_first(b);
          end
        LX_NUMBER:
          if (is_num(b)) grow();
          else begin
            push_tok(K_NUMBER, tok_len);
            lex_first(b);
          end
        LX_PLUS:  lex_op(b, K_PLUS, "+", K_INC, ChNul, 6'd0);
        LX_MINUS: lex_op(b, K_MINUS, "-", K_DEC, ">", K_ARROW);
        LX_EQ:    lex_op(b, K_ASSIGN, "=", K_EQ, ChNul, 6'd0);
        LX_LT:    lex_op(b, K_LT, "=", K_LE, ChNul, 6'd0);
        LX_GT:    lex_op(b, K_GT, "=", K_GE, ChNul, 6'd0);
        LX_NOT:   lex_op(b, K_NOT, "=", K_NE, ChNul, 6'd0);
        LX_AMP:   lex_op(b, K_AMP, "&", K_LAND, ChNul, 6'd0);
        LX_OR:    lex_op(b, K_OR, "|", K_LOR, "=", K_OREQ);
        LX_SLASH:
          if (b == "*") lx = LX_COMMENT;
          else lex_op(b, K_DIV, "=", K_DIVEQ, ChNul, 6'd0);
        LX_COMMENT:
          if (b == ChNul) lex_error(b);
          else if (b == "*") lx = LX_COMMENT_STAR;
        LX_COMMENT_STAR:
          if (b == ChNul) lex_error(b);
          else if (b == "/") lx = LX_START;
          else if (b != "*") lx = LX_COMMENT;
        LX_STR:
          if (b == ChNul) lex_error(b);
          else begin
            grow();
            if (b == 8'h22) begin
              push_tok(K_STRING, tok_len);
              lx = LX_START;
            end else if (b == "\\") begin
              lx = LX_STR_ESC;
            end
          end
        LX_STR_ESC:
          if (b == ChNul) lex_error(b);
          else begin
            grow();
            lx = LX_STR;
          end
        LX_CHR_OPEN:
          if (b == ChNul || b == 8'h27) lex_error(b);
          else begin
            grow();
            lx = (b == "\\") ? LX_CHR_ESC : LX_CHR_CLOSE;
          end
        LX_CHR_ESC:
          if (b == ChNul) lex_error(b);
          else begin
            grow();
            lx = LX_CHR_CLOSE;
          end
        LX_CHR_CLOSE:
          if (b == 8'h27) begin
            grow();
            push_tok(K_CHAR, tok_len);
            lx = LX_START;
          end else begin
            lex_error(b);
          end
        LX_PP_NAME: lex_pp_name(b);
        LX_PP_BODY: lex_pp_body(b);
        LX_PP_ESC:
          if (b == ChNul) begin
            push_tok(K_PREPROC, tok_len);
            lex_first(b);
          end else begin
            grow();
            lx = LX_PP_BODY;
          end
        default: lex_first(b);
      endcase
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
  endfunction

  assign pending_count = expected_tokens.size();

  always @(posedge clk) begin
    token_t want;
    if (!rst_n) begin
      lx = LX_START;
      cand = '1;
      tok_len = 0;
      in_error = 0;
      expected_tokens.delete();
      fail_count <= 0;
      token_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        token_count <= token_count + 1;
        if (expected_tokens.size() == 0) begin
          $error("unexpected token: kind %0d length %0d", out_token_kind, out_token_length);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_tokens.pop_front();
          if (out_token_kind !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, out_token_kind);
            fail_count <= fail_count + 1;
          end else if (out_token_length !== want.len) begin
            $error("token_length: expected %0d, got %0d", want.len, out_token_length);
            fail_count <= fail_count + 1;
          end else if (out_last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, out_last_of_run);
            fail_count <= fail_count + 1;
          end
        end
      end
      // results of a byte can leave no earlier than the cycle after its transfer
      if (in_valid && !in_stall) begin
        lex_byte(in_text_byte);
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
      end
    end
  end

endmodule

// ===== bench/tb_c_source_tokenizer.sv =====
// Testbench top: drives C text into the tokenizer and reports the verdict.
`timescale 1ns / 1ps
module tb_c_source_tokenizer;
  import cst_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_text_byte;
  logic       out_valid;
  logic       out_stall;
  logic [5:0] out_token_kind;
  logic [7:0] out_token_length;
  logic       out_last_of_run;
  int         fail_count;
  int         pending_count;
  int         token_count;

  // idle percentages for sender and receiver, changed per phase
  int gap_pct;
  int stall_pct;
  int bytes_sent;
  bit [255:0] seen_bytes;

  byte unsigned text_q[$];

  c_source_tokenizer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_text_byte(in_text_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_token_kind(out_token_kind),
    .out_token_length(out_token_length), .out_last_of_run(out_last_of_run)
  );

  tok_scoreboard checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_text_byte(in_text_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_token_kind(out_token_kind),
    .out_token_length(out_token_length), .out_last_of_run(out_last_of_run),
    .fail_count(fail_count), .pending_count(pending_count), .token_count(token_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls at the current rate, redrawn every edge.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Timeout: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // End-of-text byte; a string literal cannot carry it.
  task automatic add_end();
    text_q.push_back(8'd0);
  endtask

  // Drain text_q one transfer per byte; valid is held while stalled.
  task automatic send_all();
    while (text_q.size() > 0) begin
      if ($urandom_range(99) < gap_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end else begin
        in_valid     <= 1'b1;
        in_text_byte <= text_q[0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        seen_bytes[text_q[0]] = 1'b1;
        void'(text_q.pop_front());
        bytes_sent++;
      end
    end
    in_valid <= 1'b0;
  endtask

  // A random well-formed-ish fragment of C source.
  task automatic add_fragment();
    string words[] = '{"char", "short", "int", "long", "unsigned", "float", "double",
      "typedef", "struct", "union", "auto", "static", "extern", "register", "if",
      "else", "while", "do", "for", "switch", "case", "default", "return", "x1",
      "ch", "unsignedx", "Return", "_tmp", "i"};
    string ops[] = '{"(", ")", "{", "}", "[", "]", ";", ",", ":", "*", "+", "++",
      "-", "--", "->", "/", "/=", "=", "==", "<", "<=", ">", ">=", "!", "!=", "&",
      "&&", "|", "||", "|=", " ", "\n", "\t"};
    string dirs[] = '{"#define X 1", "#else", "#endif", "#if A", "#ifdef B",
      "#ifndef C", "#include <a.h>", "#line 4", "#undef X", "#ifx", "#undee",
      "#define L a\\\nb"};
    case ($urandom_range(9))
      0, 1, 2: add_text(words[$urandom_range(words.size() - 1)]);
      3, 4: add_text(ops[$urandom_range(ops.size() - 1)]);
      5: begin
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(48, 57)));
      end
      6: begin
        text_q.push_back(8'h22);
        repeat ($urandom_range(0, 5)) text_q.push_back(8'($urandom_range(1, 255)));
        text_q.push_back(8'h22);
      end
      7: begin
        add_text("'");
        if ($urandom_range(1)) add_text("\\");
        text_q.push_back(8'($urandom_range(1, 255)));
        add_text("'");
      end
      8: begin
        add_text(dirs[$urandom_range(dirs.size() - 1)]);
        add_text("\n");
      end
      default: begin
        add_text("/*");
        repeat ($urandom_range(0, 4)) text_q.push_back(8'($urandom_range(1, 255)));
        add_text("**/");
      end
    endcase
    if ($urandom_range(3) == 0) add_text(" ");
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_text_byte = 8'd0;
    out_stall = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    bytes_sent = 0;
    seen_bytes = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every operator, keywords, literals, directives and error paths.
    add_text("int x1=a+b;}");
    add_end();
    add_text("(){}[];,:*++--->/= == <= >= != && || |= < > ! & | / -");
    add_end();
    add_text("\"a\\\"b\" 'c' '\\n' 1234 /* c ** */ unsignedx");
    add_end();
    add_text("#include <s>\n#ifx\n#undef Q\n#undee");
    add_end();
    add_text("$junk ''");
    add_end();
    add_text("'ab'");
    add_end();
    add_text("\"open");
    add_end();
    add_text("/* open");
    add_end();
    add_text("#ifd");
    add_end();
    add_text("#def \\");
    add_end();
    text_q.push_back(8'hFF);
    text_q.push_back(8'h80);
    text_q.push_back(8'd0);
    repeat (300) text_q.push_back("a");   // length saturation
    text_q.push_back(8'd0);
    send_all();

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct   = (ph == 1) ? 70 : (ph == 3) ? 33 : 0;
      stall_pct = (ph == 2) ? 70 : (ph == 3) ? 33 : 0;
      repeat (180 / 4) begin
        if ($urandom_range(9) == 0) text_q.push_back(8'($urandom_range(255)));
        else add_fragment();
        if ($urandom_range(15) == 0) text_q.push_back(8'd0);
      end
      text_q.push_back(8'd0);
      send_all();
    end
    // cover every byte value at least once
    for (int v = 0; v < 256; v++) if (!seen_bytes[v]) text_q.push_back(8'(v));
    text_q.push_back(8'd0);
    send_all();

    stall_pct = 0;
    while (pending_count > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d text bytes and checked %0d tokens across four pacing phases",
             bytes_sent, token_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cst_pkg.sv
sv/cst_scan.sv
sv/cst_queue.sv
sv/cst_emit.sv
sv/c_source_tokenizer.sv
bench/tok_scoreboard.sv
bench/tb_c_source_tokenizer.sv
